// File: design/mjq_pkg.sv
// shared constants, types and helpers for the minimum-jerk quintic evaluator
// no dependencies; every other file of the block imports this package

package mjq_pkg;

  // default width of positions, velocities and accelerations
  localparam int VALUE_WIDTH_DEF = 32;

  // time sample: unsigned, 16 fraction bits, 65536 is one
  localparam int TIME_W    = 17;
  localparam int TIME_FRAC = 16;

  // doubled coefficients need 8 bits over the register width,
  // the horner accumulator 13 bits (bound 3258 * 2^(w-1) at t < 2)
  localparam int COEF_GUARD = 8;
  localparam int ACC_GUARD  = 13;

  localparam int NUM_COEF  = 6;
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;

  // register map, in address order
  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_POSITION,
    REG_START_VELOCITY,
    REG_START_ACCEL,
    REG_END_POSITION,
    REG_END_VELOCITY,
    REG_END_ACCEL
  } reg_idx_t;

  // apb data width: 32 bits, 64 once a register no longer fits
  function automatic int cfg_data_w(input int vw);
    return (vw > 32) ? 64 : 32;
  endfunction

  // lowest address bit that selects a register
  function automatic int cfg_addr_lsb(input int vw);
    return (vw > 32) ? 3 : 2;
  endfunction

  function automatic int cfg_addr_w(input int vw);
    return cfg_addr_lsb(vw) + REG_IDX_W;
  endfunction

endpackage

// File: design/mjq_ifs.sv
// valid/ready channel interfaces for time samples and positions
// depends on mjq_pkg for the sample width and the default value width

interface mjq_in_if;
  import mjq_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_norm;

  modport source (output valid, output time_norm, input ready);
  modport sink   (input valid, input time_norm, output ready);
endinterface

interface mjq_out_if #(
  parameter int VALUE_WIDTH = mjq_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] position;
  logic                          saturated;

  modport source (output valid, output position, output saturated, input ready);
  modport sink   (input valid, input position, input saturated, output ready);
endinterface

// File: design/mjq_coef.sv
// doubled quintic coefficients from the six boundary registers
// two register stages of constant-weight sums; depends on mjq_pkg

module mjq_coef #(
  parameter int VALUE_WIDTH = mjq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic signed [VALUE_WIDTH-1:0]                     x0_i,
  input  logic signed [VALUE_WIDTH-1:0]                     v0_i,
  input  logic signed [VALUE_WIDTH-1:0]                     a0_i,
  input  logic signed [VALUE_WIDTH-1:0]                     x1_i,
  input  logic signed [VALUE_WIDTH-1:0]                     v1_i,
  input  logic signed [VALUE_WIDTH-1:0]                     a1_i,
  output logic signed [VALUE_WIDTH+mjq_pkg::COEF_GUARD-1:0] coef_o [mjq_pkg::NUM_COEF]
);
  import mjq_pkg::*;

  localparam int COEF_W = VALUE_WIDTH + COEF_GUARD;

  typedef logic signed [COEF_W-1:0] coef_t;

  function automatic coef_t ext(input logic signed [VALUE_WIDTH-1:0] v);
    return coef_t'(v);
  endfunction

  function automatic coef_t scale(input coef_t v, input coef_t k);
    return v * k;
  endfunction

  coef_t x0, v0, a0, x1, v1, a1, dx;

  // first stage: three partial sums per higher coefficient
  coef_t d0_r, d1_r, d2_r;
  coef_t p3a_r, p3b_r, p3c_r;
  coef_t p4a_r, p4b_r, p4c_r;
  coef_t p5a_r, p5b_r, p5c_r;
  coef_t p3a_nxt, p3b_nxt, p3c_nxt;
  coef_t p4a_nxt, p4b_nxt, p4c_nxt;
  coef_t p5a_nxt, p5b_nxt, p5c_nxt;

  // second stage: finished coefficients
  coef_t coef_r [NUM_COEF];

  always_comb begin
    x0 = ext(x0_i);
    v0 = ext(v0_i);
    a0 = ext(a0_i);
    x1 = ext(x1_i);
    v1 = ext(v1_i);
    a1 = ext(a1_i);
    dx = x1 - x0;

    // d3 = -3a0 - 12v0 + 20(x1-x0) + a1 - 8v1
    p3a_nxt = -scale(a0, coef_t'(3)) - scale(v0, coef_t'(12));
    p3b_nxt = scale(dx, coef_t'(20));
    p3c_nxt = a1 - scale(v1, coef_t'(8));
    // d4 = 3a0 + 16v0 - 30(x1-x0) - 2a1 + 14v1
    p4a_nxt = scale(a0, coef_t'(3)) + scale(v0, coef_t'(16));
    p4b_nxt = -scale(dx, coef_t'(30));
    p4c_nxt = scale(v1, coef_t'(14)) - scale(a1, coef_t'(2));
    // d5 = -a0 - 6v0 + 12(x1-x0) + a1 - 6v1
    p5a_nxt = -a0 - scale(v0, coef_t'(6));
    p5b_nxt = scale(dx, coef_t'(12));
    p5c_nxt = a1 - scale(v1, coef_t'(6));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r  <= '0;
      d1_r  <= '0;
      d2_r  <= '0;
      p3a_r <= '0;
      p3b_r <= '0;
      p3c_r <= '0;
      p4a_r <= '0;
      p4b_r <= '0;
      p4c_r <= '0;
      p5a_r <= '0;
      p5b_r <= '0;
      p5c_r <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      d0_r  <= scale(x0, coef_t'(2));
      d1_r  <= scale(v0, coef_t'(2));
      d2_r  <= a0;
      p3a_r <= p3a_nxt;
      p3b_r <= p3b_nxt;
      p3c_r <= p3c_nxt;
      p4a_r <= p4a_nxt;
      p4b_r <= p4b_nxt;
      p4c_r <= p4c_nxt;
      p5a_r <= p5a_nxt;
      p5b_r <= p5b_nxt;
      p5c_r <= p5c_nxt;
      coef_r[0] <= d0_r;
      coef_r[1] <= d1_r;
      coef_r[2] <= d2_r;
      coef_r[3] <= p3a_r + p3b_r + p3c_r;
      coef_r[4] <= p4a_r + p4b_r + p4c_r;
      coef_r[5] <= p5a_r + p5b_r + p5c_r;
    end
  end

  assign coef_o = coef_r;

endmodule

// File: design/mjq_horner_step.sv
// one horner step: acc_o = round(acc_i * t / 2^16) + coef, ties away from zero
// three register stages (magnitude, split multiply, combine and add); uses mjq_pkg

module mjq_horner_step #(
  parameter int VALUE_WIDTH = mjq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              valid_i,
  input  logic signed [VALUE_WIDTH+mjq_pkg::ACC_GUARD-1:0]  acc_i,
  input  logic [mjq_pkg::TIME_W-1:0]                        time_i,
  input  logic signed [VALUE_WIDTH+mjq_pkg::COEF_GUARD-1:0] coef_i,
  output logic                                              valid_o,
  output logic signed [VALUE_WIDTH+mjq_pkg::ACC_GUARD-1:0]  acc_o,
  output logic [mjq_pkg::TIME_W-1:0]                        time_o
);
  import mjq_pkg::*;

  localparam int ACC_W  = VALUE_WIDTH + ACC_GUARD;
  localparam int COEF_W = VALUE_WIDTH + COEF_GUARD;
  localparam int LO_W   = (ACC_W + 1) / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PROD_W = ACC_W + TIME_W;
  localparam int SUM_W  = ACC_W + 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (TIME_FRAC - 1);

  // stage 1: sign and magnitude
  logic                  v1_r, n1_r;
  logic [ACC_W-1:0]      mag_r, mag_nxt;
  logic [TIME_W-1:0]     t1_r;
  // stage 2: two partial products
  logic                  v2_r, n2_r;
  logic [LO_W+TIME_W-1:0] lo_r, lo_nxt;
  logic [HI_W+TIME_W-1:0] hi_r, hi_nxt;
  logic [TIME_W-1:0]     t2_r;
  // stage 3: rounded product added to the coefficient
  logic                  v3_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [TIME_W-1:0]     t3_r;

  logic [PROD_W-1:0]       full;
  logic [ACC_W-1:0]        rnd;
  logic signed [SUM_W-1:0] coef_ext, rnd_ext, sum;

  always_comb begin
    mag_nxt = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    lo_nxt  = (LO_W+TIME_W)'(mag_r[LO_W-1:0]) * (LO_W+TIME_W)'(t1_r);
    hi_nxt  = (HI_W+TIME_W)'(mag_r[ACC_W-1:LO_W]) * (HI_W+TIME_W)'(t1_r);

    // recombine the halves and round half up on the magnitude
    full     = {hi_r, LO_W'(0)} + PROD_W'(lo_r) + HALF;
    rnd      = full[TIME_FRAC +: ACC_W];
    coef_ext = signed'({{(SUM_W-COEF_W){coef_i[COEF_W-1]}}, coef_i});
    rnd_ext  = signed'({1'b0, rnd});
    sum      = n2_r ? (coef_ext - rnd_ext) : (coef_ext + rnd_ext);
    acc_nxt  = signed'(sum[ACC_W-1:0]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= acc_i[ACC_W-1];
      mag_r <= mag_nxt;
      t1_r  <= time_i;
      n2_r  <= n1_r;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      t2_r  <= t1_r;
      acc_r <= acc_nxt;
      t3_r  <= t2_r;
    end
  end

  assign valid_o = v3_r;
  assign acc_o   = acc_r;
  assign time_o  = t3_r;

endmodule

// File: design/min_jerk_quintic_eval.sv
// results pass the lead-in registers, horner chain, halving and output registers
// one transaction per cycle when not stalled; five three-stage horner steps
// a stalled output holds the whole pipeline; nothing is lost or repeated
// coefficients follow a write via the partial-sum and coefficient registers
// reset clears the six registers, the coefficients and all valid bits
// top level: apb registers, coefficient unit, horner chain, rounding, saturation

module min_jerk_quintic_eval #(
  parameter int VALUE_WIDTH = mjq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [mjq_pkg::cfg_addr_w(VALUE_WIDTH)-1:0]   paddr,
  input  logic [mjq_pkg::cfg_data_w(VALUE_WIDTH)-1:0]   pwdata,
  output logic [mjq_pkg::cfg_data_w(VALUE_WIDTH)-1:0]   prdata,
  output logic                                          pready,
  mjq_in_if.sink                                        in_ch,
  mjq_out_if.source                                     out_ch
);
  import mjq_pkg::*;

  localparam int DATA_W   = cfg_data_w(VALUE_WIDTH);
  localparam int ADDR_LSB = cfg_addr_lsb(VALUE_WIDTH);
  localparam int ACC_W    = VALUE_WIDTH + ACC_GUARD;
  localparam int COEF_W   = VALUE_WIDTH + COEF_GUARD;
  localparam int NSTEP    = NUM_COEF - 1;

  // ---------------- configuration registers ----------------
  logic [VALUE_WIDTH-1:0] cfg_r [NUM_REGS];
  reg_idx_t               reg_sel;
  logic                   reg_ok;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_LSB +: REG_IDX_W]);
  assign reg_ok  = (reg_sel <= REG_END_ACCEL);
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = reg_ok ? DATA_W'(cfg_r[reg_sel]) : '0;

  // register write, unknown addresses dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (wr_en && reg_ok) begin
      cfg_r[reg_sel] <= pwdata[VALUE_WIDTH-1:0];
    end
  end

  // ---------------- coefficients ----------------
  logic signed [COEF_W-1:0] coef [NUM_COEF];

  mjq_coef #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .x0_i   (signed'(cfg_r[REG_START_POSITION])),
    .v0_i   (signed'(cfg_r[REG_START_VELOCITY])),
    .a0_i   (signed'(cfg_r[REG_START_ACCEL])),
    .x1_i   (signed'(cfg_r[REG_END_POSITION])),
    .v1_i   (signed'(cfg_r[REG_END_VELOCITY])),
    .a1_i   (signed'(cfg_r[REG_END_ACCEL])),
    .coef_o (coef)
  );

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // two lead-in stages, with the leading coefficient taken as the first
  // step samples it, so that an item taken right after a write meets it
  logic              p1_v_r, p2_v_r;
  logic [TIME_W-1:0] p1_t_r, p2_t_r;

  // horner chain, highest coefficient first
  logic                    chain_v   [NSTEP+1];
  logic signed [ACC_W-1:0] chain_acc [NSTEP+1];
  logic [TIME_W-1:0]       chain_t   [NSTEP+1];

  assign chain_v[0]   = p2_v_r;
  assign chain_acc[0] = ACC_W'(coef[NSTEP]);
  assign chain_t[0]   = p2_t_r;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    mjq_horner_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_v[k]),
      .acc_i   (chain_acc[k]),
      .time_i  (chain_t[k]),
      .coef_i  (coef[NSTEP-1-k]),
      .valid_o (chain_v[k+1]),
      .acc_o   (chain_acc[k+1]),
      .time_o  (chain_t[k+1])
    );
  end

  // halving with rounding to nearest, ties away from zero
  logic                    h_v_r;
  logic signed [ACC_W-1:0] h_pos_r, h_pos_nxt;
  logic signed [ACC_W-1:0] acc_fin;

  assign acc_fin   = chain_acc[NSTEP];
  assign h_pos_nxt = (acc_fin >>> 1) +
                     signed'(ACC_W'(acc_fin[0] & ~acc_fin[ACC_W-1]));

  // saturation to the register range
  logic                          sat_nxt;
  logic signed [VALUE_WIDTH-1:0] pos_nxt;
  logic signed [VALUE_WIDTH-1:0] pos_r;
  logic                          sat_r;
  logic [ACC_W-VALUE_WIDTH:0]    top_bits;

  always_comb begin
    top_bits = h_pos_r[ACC_W-1:VALUE_WIDTH-1];
    sat_nxt  = !((&top_bits) || !(|top_bits));
    if (!sat_nxt) begin
      pos_nxt = signed'(h_pos_r[VALUE_WIDTH-1:0]);
    end else if (h_pos_r[ACC_W-1]) begin
      pos_nxt = signed'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    end else begin
      pos_nxt = signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      h_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= in_ch.valid;
      p2_v_r      <= p1_v_r;
      h_v_r       <= chain_v[NSTEP];
      out_valid_r <= h_v_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      p1_t_r   <= in_ch.time_norm;
      p2_t_r   <= p1_t_r;
      h_pos_r  <= h_pos_nxt;
      pos_r    <= pos_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = pos_r;
  assign out_ch.saturated = sat_r;

endmodule

// File: dv/tb.sv
// self-checking testbench for min_jerk_quintic_eval: positions are checked against a
// built-in quintic predictor under random idling, back-pressure and register rewrites
// depends on mjq_pkg, the mjq_in_if / mjq_out_if interfaces and the block's rtl
`timescale 1ns / 1ps

module tb;
  import mjq_pkg::*;

  localparam int VW           = VALUE_WIDTH_DEF;
  localparam int DATA_W       = cfg_data_w(VW);
  localparam int ADDR_W       = cfg_addr_w(VW);
  localparam int ADDR_LSB     = cfg_addr_lsb(VW);
  localparam int FRAC_BITS    = 16;
  localparam int PIPE_LATENCY = 18;
  localparam int CYCLE_LIMIT  = 500000;

  // register indexes that decode to no register
  localparam int REG_UNUSED_LO = NUM_REGS;
  localparam int REG_UNUSED_HI = (1 << REG_IDX_W) - 1;

  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1 << TIME_FRAC);
  localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'((1 << TIME_W) - 1);

  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0] VAL_ONE = VW'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [VW-1:0] position;
    logic                 saturated;
  } position_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mjq_in_if                     in_ch ();
  mjq_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  min_jerk_quintic_eval #(.VALUE_WIDTH(VW)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // boundary registers as the block should hold them
  logic signed [VW-1:0] bound_regs [NUM_REGS];
  position_t            expected_positions [$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  bit                   src_idle = 1'b0;
  bit                   snk_idle = 1'b0;
  int                   sink_hold_req = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // quintic from doubled coefficients, horner in time, halve, saturate
  function automatic position_t predict_position(input logic [TIME_W-1:0] t);
    logic signed [127:0] x0, v0, a0, x1, v1, a1, acc, hi_b, lo_b;
    logic signed [127:0] dcoef [NUM_COEF];
    logic [127:0]        mag;
    logic                neg;
    int                  i;
    position_t           res;
    x0 = bound_regs[REG_START_POSITION];
    v0 = bound_regs[REG_START_VELOCITY];
    a0 = bound_regs[REG_START_ACCEL];
    x1 = bound_regs[REG_END_POSITION];
    v1 = bound_regs[REG_END_VELOCITY];
    a1 = bound_regs[REG_END_ACCEL];
    dcoef[0] = 2 * x0;
    dcoef[1] = 2 * v0;
    dcoef[2] = a0;
    dcoef[3] = -3 * a0 - 12 * v0 - 20 * x0 + a1 - 8 * v1 + 20 * x1;
    dcoef[4] = 3 * a0 + 16 * v0 + 30 * x0 - 2 * a1 + 14 * v1 - 30 * x1;
    dcoef[5] = -a0 - 6 * v0 - 12 * x0 + a1 - 6 * v1 + 12 * x1;
    acc = dcoef[NUM_COEF - 1];
    for (i = NUM_COEF - 2; i >= 0; i--) begin
      // scale by time, rounding half away from zero on the magnitude
      neg = acc < 0;
      mag = neg ? -acc : acc;
      mag = (mag * t + (128'd1 << (TIME_FRAC - 1))) >> TIME_FRAC;
      acc = neg ? -$signed(mag) : $signed(mag);
      acc = acc + dcoef[i];
      if (acc > (128'sd1 <<< 61)) acc = 128'sd1 <<< 61;
      else if (acc < -(128'sd1 <<< 61)) acc = -(128'sd1 <<< 61);
    end
    // undo the doubling, ties away from zero
    neg = acc < 0;
    mag = neg ? -acc : acc;
    mag = (mag + 128'd1) >> 1;
    acc = neg ? -$signed(mag) : $signed(mag);
    hi_b = (128'sd1 <<< (VW - 1)) - 128'sd1;
    lo_b = -hi_b - 128'sd1;
    res.saturated = 1'b0;
    if (acc > hi_b) begin
      acc = hi_b;
      res.saturated = 1'b1;
    end else if (acc < lo_b) begin
      acc = lo_b;
      res.saturated = 1'b1;
    end
    res.position = acc[VW-1:0];
    return res;
  endfunction

  // result side: per-transaction stall, or one long hold when requested
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 10) : 0;
      if (sink_hold_req > 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // compare every position transaction with the oldest expectation
  always @(posedge clk) begin : position_check
    position_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_positions.size() == 0) begin
        mismatch_count++;
        $error("position: unexpected transaction, got %0d saturated %0b",
               out_ch.position, out_ch.saturated);
      end else begin
        want = expected_positions.pop_front();
        if (out_ch.position !== want.position) begin
          mismatch_count++;
          $error("position: expected %0d, got %0d", want.position, out_ch.position);
        end
        if (out_ch.saturated !== want.saturated) begin
          mismatch_count++;
          $error("saturated: expected %0b, got %0b", want.saturated, out_ch.saturated);
        end
      end
    end
  end

  // offer one time sample, after a random gap when the source idles, and log its expected position
  task automatic send_sample(input logic [TIME_W-1:0] t);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.time_norm <= t;
    do @(posedge clk); while (!in_ch.ready);
    expected_positions.push_back(predict_position(t));
  endtask

  // stop offering and wait until every expected position has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_positions.size() != 0);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    case ($urandom_range(0, 9))
      8: return TIME_W'($urandom_range(TIME_ONE + 1, TIME_MAX));
      9: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return TIME_W'(1);
          2: return TIME_ONE;
          default: return TIME_MAX;
        endcase
      end
      default: return TIME_W'($urandom_range(0, TIME_ONE));
    endcase
  endfunction

  // apb write: setup then access, then back to idle
  task automatic reg_write(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << ADDR_LSB);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < NUM_REGS) bound_regs[idx] = value[VW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read every register back; also lets new coefficients settle
  task automatic verify_registers();
    for (int i = 0; i < NUM_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(i << ADDR_LSB);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[VW-1:0] !== bound_regs[i]) begin
        mismatch_count++;
        $error("register %0d readback: expected %0h, got %0h", i, bound_regs[i],
               prdata[VW-1:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_profile(input logic [VW-1:0] x0, input logic [VW-1:0] v0,
                             input logic [VW-1:0] a0, input logic [VW-1:0] x1,
                             input logic [VW-1:0] v1, input logic [VW-1:0] a1);
    wait_drained();
    reg_write(REG_START_POSITION, DATA_W'(x0));
    reg_write(REG_START_VELOCITY, DATA_W'(v0));
    reg_write(REG_START_ACCEL, DATA_W'(a0));
    reg_write(REG_END_POSITION, DATA_W'(x1));
    reg_write(REG_END_VELOCITY, DATA_W'(v1));
    reg_write(REG_END_ACCEL, DATA_W'(a1));
    verify_registers();
  endtask

  // registers straight out of reset give a flat zero trajectory
  task automatic test_reset_state();
    verify_registers();
    send_sample('0);
    send_sample(TIME_ONE);
    send_sample(TIME_MAX);
  endtask

  // unit move, corner times, extrapolation and saturation
  task automatic test_directed_profiles();
    set_profile('0, '0, '0, VAL_ONE, '0, '0);
    send_sample('0);
    send_sample(TIME_W'(1));
    send_sample(TIME_ONE >> 1);
    send_sample(TIME_ONE - 1);
    send_sample(TIME_ONE);
    send_sample(TIME_MAX);
    // start conditions only: -1.5, 2.0, -3.0
    set_profile(-(VAL_ONE + (VAL_ONE >> 1)), VAL_ONE << 1, -(VAL_ONE * 3), '0, '0, '0);
    send_sample(TIME_W'(1));
    send_sample(TIME_ONE - 1);
    // opposing extremes drive the result into both bounds
    set_profile(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
    send_sample('0);
    send_sample(TIME_ONE);
    send_sample(TIME_MAX);
    set_profile(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_sample(TIME_ONE >> 1);
    send_sample(TIME_MAX);
    set_profile(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
    send_sample(TIME_ONE);
    send_sample(TIME_MAX);
  endtask

  // writes to undecoded indexes must leave the trajectory alone
  task automatic test_unknown_index();
    wait_drained();
    reg_write(REG_UNUSED_LO, DATA_W'(VAL_MAX));
    reg_write(REG_UNUSED_HI, '1);
    verify_registers();
    send_sample('0);
    send_sample(TIME_ONE);
  endtask

  // random boundary conditions per phase, with each idling mix
  task automatic test_random_profiles();
    logic [VW-1:0] vals [NUM_REGS];
    for (int phase = 0; phase < 22; phase++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case ($urandom_range(0, 7))
          0, 1, 2: vals[r] = VW'($urandom_range(0, 1 << 21) - (1 << 20));
          3, 4:    vals[r] = VW'($urandom_range(0, 1 << 27) - (1 << 26));
          5:       vals[r] = VW'($urandom());
          default: begin
            case ($urandom_range(0, 3))
              0: vals[r] = VAL_MAX;
              1: vals[r] = VAL_MIN;
              2: vals[r] = '0;
              default: vals[r] = '1;
            endcase
          end
        endcase
      end
      wait_drained();
      if ($urandom_range(0, 3) == 0)
        reg_write($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), DATA_W'($urandom()));
      set_profile(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]);
      src_idle = (phase % 4 == 0) || (phase % 4 == 2);
      snk_idle = (phase % 4 == 0) || (phase % 4 == 3);
      for (int k = 0; k < 50; k++) send_sample(random_time());
    end
  endtask

  // long receiver hold while samples keep coming: the pipeline fills and stalls
  task automatic test_output_backpressure();
    src_idle      = 1'b0;
    snk_idle      = 1'b1;
    sink_hold_req = 300;
    for (int k = 0; k < 120; k++) send_sample(random_time());
  endtask

  // sender pauses until the pipeline has emptied, then resumes
  task automatic test_drain_and_resume();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    for (int k = 0; k < 60; k++) send_sample(random_time());
    wait_drained();
    for (int k = 0; k < 60; k++) send_sample(random_time());
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.time_norm <= '0;
    for (int r = 0; r < NUM_REGS; r++) bound_regs[r] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_profiles();
    test_unknown_index();
    test_random_profiles();
    test_output_backpressure();
    test_drain_and_resume();

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
